### rtl/itp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, constants and helpers for the indexed texel palette expander.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int PIXEL_CODES         = 256;
    localparam int NIBBLE_W            = 4;
    localparam int COLOR_W             = 32;
    localparam int PIXEL_W             = 8;
    localparam int S_TDATA_W           = 40;

    typedef enum logic {
        MODE_PALETTE = 1'b0,
        MODE_PIXEL   = 1'b1
    } item_mode_t;

    typedef enum logic {
        FMT_8BIT = 1'b0,
        FMT_4BIT = 1'b1
    } pix_fmt_t;

    // stored word has the first file byte low; colors go out red-first
    function automatic logic [COLOR_W-1:0] byte_reverse(input logic [COLOR_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage
`default_nettype wire

### rtl/itp_load_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_load_ctrl
// Running palette load position and the write address derived from it.
// ----------------------------------------------------------------------------
module itp_load_ctrl #(
    parameter int PALETTE_ENTRIES = itp_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  itp_pkg::pix_fmt_t                    fmt,
    input  logic                                 advance,
    output logic [$clog2(PALETTE_ENTRIES)-1:0]   wr_addr
);
    import itp_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [AW-1:0]       pos_reg;
    logic [AW-1:0]       pos_next;
    logic [AW:0]         pos_ext;
    logic [AW:0]         swapped;
    logic [NIBBLE_W-1:0] small_next;

    always_comb
    begin
        pos_ext    = {1'b0, pos_reg};
        // clut unswizzle: exchange bits 3 and 4
        swapped    = pos_ext;
        swapped[4] = pos_ext[3];
        swapped[3] = pos_ext[4];
        small_next = pos_reg[NIBBLE_W-1:0] + NIBBLE_W'(1);

        case (fmt)
            FMT_8BIT:
            begin
                if (swapped >= (AW+1)'(PALETTE_ENTRIES))
                begin
                    wr_addr = AW'(swapped - (AW+1)'(PALETTE_ENTRIES));
                end
                else
                begin
                    wr_addr = AW'(swapped);
                end
                if (pos_reg == AW'(PALETTE_ENTRIES - 1))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + AW'(1);
                end
            end
            FMT_4BIT:
            begin
                wr_addr  = AW'(pos_reg[NIBBLE_W-1:0]);
                pos_next = AW'(small_next);
            end
            default:
            begin
                wr_addr  = pos_reg;
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule
`default_nettype wire

### rtl/itp_palette_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_palette_ram
// Palette memory, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module itp_palette_ram #(
    parameter int PALETTE_ENTRIES = itp_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [$clog2(PALETTE_ENTRIES)-1:0] wr_addr,
    input  logic [itp_pkg::COLOR_W-1:0]        wr_data,
    input  logic                               rd_en,
    input  logic [$clog2(PALETTE_ENTRIES)-1:0] rd_addr,
    output logic [itp_pkg::COLOR_W-1:0]        rd_data
);
    import itp_pkg::*;

    logic [COLOR_W-1:0] mem [PALETTE_ENTRIES];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/indexed_texel_palette_expander.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_texel_palette_expander
// Loads a 32-bit color palette and expands 8-bit or 4-bit pixel indices
// into byte-reversed rgba colors.
// ----------------------------------------------------------------------------
// order: a beat is held in the input register, then its color is read into the
//   registered palette read data that drives m_tdata
// throughput: palette beats one per cycle; 8-bit pixels and 4-bit colors one per
//   cycle while m_tready allows, from the single palette read port; a 4-bit byte gives two colors
// reset: control state and load position clear; palette contents are
//   undefined until loaded, no clearing pass
module indexed_texel_palette_expander #(
    parameter int PALETTE_ENTRIES = itp_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [itp_pkg::S_TDATA_W-1:0] s_tdata,  // palette_word [31:0], pixel_byte [39:32]
    input  logic [0:0]                    s_tuser,  // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [itp_pkg::COLOR_W-1:0]   m_tdata,  // color [31:0]
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_data  // pixel_format
);
    import itp_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    typedef logic [AW-1:0] wrap_tab_t [PIXEL_CODES];

    function automatic wrap_tab_t build_wrap_tab();
        wrap_tab_t t;
        for (int i = 0; i < PIXEL_CODES; i++)
        begin
            t[i] = AW'(i % PALETTE_ENTRIES);
        end
        return t;
    endfunction

    localparam wrap_tab_t WRAP_TAB = build_wrap_tab();

    pix_fmt_t           fmt_reg;
    logic               iss_valid_reg;
    logic               iss_valid_next;
    item_mode_t         iss_mode_reg;
    logic [COLOR_W-1:0] iss_word_reg;
    logic [PIXEL_W-1:0] iss_pix_reg;
    logic               iss_hi_reg;
    logic               iss_hi_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_last_reg;

    logic               in_fire;
    logic               rd_ready;
    logic               is_load;
    logic               is_pixel;
    logic               rd_en;
    logic               rd_last;
    logic               iss_done;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [COLOR_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_8BIT;
        end
        else if (cfg_valid)
        begin
            fmt_reg <= pix_fmt_t'(cfg_data[0]);
        end
    end

    // issue stage
    always_comb
    begin
        rd_ready = !out_valid_reg || m_tready;
        is_load  = iss_valid_reg && (iss_mode_reg == MODE_PALETTE);
        is_pixel = iss_valid_reg && (iss_mode_reg == MODE_PIXEL);
        rd_en    = is_pixel && rd_ready;
        case (fmt_reg)
            FMT_8BIT:
            begin
                rd_last = 1'b1;
                rd_addr = WRAP_TAB[iss_pix_reg];
            end
            FMT_4BIT:
            begin
                // low nibble first
                rd_last = iss_hi_reg;
                if (iss_hi_reg)
                begin
                    rd_addr = AW'(iss_pix_reg[PIXEL_W-1:NIBBLE_W]);
                end
                else
                begin
                    rd_addr = AW'(iss_pix_reg[NIBBLE_W-1:0]);
                end
            end
            default:
            begin
                rd_last = 1'b1;
                rd_addr = '0;
            end
        endcase
        iss_done = is_load || (rd_en && rd_last);
        s_tready = !iss_valid_reg || iss_done;
        in_fire  = s_tvalid && s_tready;

        if (in_fire)
        begin
            iss_valid_next = 1'b1;
            iss_hi_next    = 1'b0;
        end
        else
        begin
            iss_valid_next = iss_valid_reg && !iss_done;
            iss_hi_next    = iss_hi_reg || (rd_en && !rd_last);
        end

        if (rd_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_valid_reg <= 1'b0;
            iss_hi_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            iss_valid_reg <= iss_valid_next;
            iss_hi_reg    <= iss_hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            iss_mode_reg <= item_mode_t'(s_tuser[0]);
            iss_word_reg <= s_tdata[COLOR_W-1:0];
            iss_pix_reg  <= s_tdata[COLOR_W+PIXEL_W-1:COLOR_W];
        end
        if (rd_en)
        begin
            out_last_reg <= rd_last;
        end
    end

    itp_load_ctrl #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_load_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .fmt     (fmt_reg),
        .advance (is_load),
        .wr_addr (wr_addr)
    );

    itp_palette_ram #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_palette_ram (
        .clk     (clk),
        .wr_en   (is_load),
        .wr_addr (wr_addr),
        .wr_data (iss_word_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = byte_reverse(rd_data);

endmodule
`default_nettype wire

### test/itp_color_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_color_checker
// Watches the palette, pixel and format channels of the expander, keeps its
// own palette image and load position, and checks every color beat in order.
// ----------------------------------------------------------------------------
module itp_color_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [itp_pkg::S_TDATA_W-1:0] s_tdata,  // palette_word [31:0], pixel_byte [39:32]
    input  logic [0:0]                    s_tuser,  // mode
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [itp_pkg::COLOR_W-1:0]   m_tdata,  // color [31:0]
    input  logic                          m_tlast,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [0:0]                    cfg_data, // pixel_format
    output int                            fail_count,
    output int                            pending,
    output int                            colors_checked
);
    import itp_pkg::*;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               last_of_run;
    } color_beat_t;

    color_beat_t        expected_colors[$];
    logic [COLOR_W-1:0] palette_image[PALETTE_ENTRIES_DEF];
    logic [7:0]         load_pos;
    pix_fmt_t           fmt;
    int                 errors;
    int                 checked;

    // stored words keep the first file byte low, colors leave red-first
    function automatic logic [COLOR_W-1:0] rgba_of(input logic [7:0] index);
        logic [COLOR_W-1:0] w;
        logic [COLOR_W-1:0] r;
        w = palette_image[index];
        for (int i = 0; i < 4; i++)
        begin
            r[8*i +: 8] = w[8*(3-i) +: 8];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        color_beat_t want;
        logic [7:0]  addr;
        logic [7:0]  pix;
        if (!rst_n)
        begin
            expected_colors.delete();
            load_pos = '0;
            fmt      = FMT_8BIT;
            errors   = 0;
            checked  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                fmt = pix_fmt_t'(cfg_data[0]);

            if (s_tvalid && s_tready)
            begin
                pix = s_tdata[COLOR_W +: PIXEL_W];
                if (item_mode_t'(s_tuser[0]) == MODE_PALETTE)
                begin
                    if (fmt == FMT_8BIT)
                    begin
                        // clut unswizzle: bits 3 and 4 of the position trade places
                        addr     = {load_pos[7:5], load_pos[3], load_pos[4], load_pos[2:0]};
                        load_pos = load_pos + 8'd1;
                    end
                    else
                    begin
                        addr     = {4'h0, load_pos[3:0]};
                        load_pos = {4'h0, load_pos[3:0] + 4'd1};
                    end
                    palette_image[addr] = s_tdata[COLOR_W-1:0];
                end
                else if (fmt == FMT_8BIT)
                begin
                    expected_colors.insert(expected_colors.size(),
                                           color_beat_t'{rgba_of(pix), 1'b1});
                end
                else
                begin
                    // low nibble goes out first
                    expected_colors.insert(expected_colors.size(),
                                           color_beat_t'{rgba_of({4'h0, pix[3:0]}), 1'b0});
                    expected_colors.insert(expected_colors.size(),
                                           color_beat_t'{rgba_of({4'h0, pix[7:4]}), 1'b1});
                end
            end

            if (m_tvalid && m_tready)
            begin
                checked++;
                if (expected_colors.size() == 0)
                begin
                    $error("color beat with nothing expected: color %h last %b",
                           m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (m_tdata !== want.color)
                    begin
                        $error("color mismatch: expected %h, got %h", want.color, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last_of_run)
                    begin
                        $error("last_of_run mismatch: expected %b, got %b",
                               want.last_of_run, m_tlast);
                        errors++;
                    end
                end
            end
        end
        fail_count     <= errors;
        pending        <= expected_colors.size();
        colors_checked <= checked;
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives palette loads, pixel bytes and format changes into the indexed
// texel palette expander under random back-pressure and source gaps.
// ----------------------------------------------------------------------------
module tb_top;
    import itp_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;
    localparam int CHUNK_ITEMS = 128;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [COLOR_W-1:0]   m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [0:0]           cfg_data  = '0;

    int fail_count;
    int pending;
    int colors_checked;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int loads_sent  = 0;
    int bytes_8bit  = 0;
    int bytes_4bit  = 0;

    // stimulus-side view of which palette entries hold a word
    bit         written[PALETTE_ENTRIES_DEF];
    logic [7:0] stim_pos = '0;
    pix_fmt_t   stim_fmt = FMT_8BIT;
    bit         full_load_done = 1'b0;

    indexed_texel_palette_expander dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    itp_color_checker color_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .colors_checked (colors_checked)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // one beat on the input channel; optionally hold off until all colors are out
    task automatic drive_beat(input item_mode_t mode, input logic [31:0] word,
                              input logic [7:0] pix, input bit drain_first);
        if (drain_first)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
        end
        // each cycle idles on its own roll
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pix, word};
        s_tuser  <= mode;
        do @(posedge clk); while (!s_tready);
        if (mode == MODE_PALETTE)
        begin
            loads_sent++;
            if (stim_fmt == FMT_8BIT)
            begin
                written[{stim_pos[7:5], stim_pos[3], stim_pos[4], stim_pos[2:0]}] = 1'b1;
                stim_pos = stim_pos + 8'd1;
            end
            else
            begin
                written[{4'h0, stim_pos[3:0]}] = 1'b1;
                stim_pos = {4'h0, stim_pos[3:0] + 4'd1};
            end
        end
        else if (stim_fmt == FMT_8BIT)
            bytes_8bit++;
        else
            bytes_4bit++;
    endtask

    // format writes only go in once the block has drained
    task automatic set_format(input pix_fmt_t fmt);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= fmt;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        stim_fmt = fmt;
    endtask

    task automatic random_item(input bit drain_first);
        logic [7:0]  b;
        logic [31:0] word;
        bit          found;
        found = 1'b0;
        b     = '0;
        word  = $urandom;
        case ($urandom_range(9))
            0: word = 32'h0000_0000;
            1: word = 32'hFFFF_FFFF;
            default: ;
        endcase
        if ($urandom_range(99) >= 20)
        begin
            for (int t = 0; t < 32 && !found; t++)
            begin
                b = 8'($urandom_range(255));
                if (stim_fmt == FMT_8BIT)
                    found = written[b];
                else
                    found = written[{4'h0, b[3:0]}] && written[{4'h0, b[7:4]}];
            end
        end
        if (found)
            drive_beat(MODE_PIXEL, word, b, drain_first);
        else
            drive_beat(MODE_PALETTE, word, 8'($urandom_range(255)), drain_first);
    endtask

    initial
    begin : stimulus
        logic [7:0] probe_bytes[5];
        probe_bytes = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'hA5};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: a full 4-bit palette with extreme words, nibble order, wrap
        set_format(FMT_4BIT);
        for (int i = 0; i < 16; i++)
        begin
            drive_beat(MODE_PALETTE, (i == 0) ? 32'h0000_0000 :
                                     (i == 15) ? 32'hFFFF_FFFF : $urandom,
                       8'($urandom_range(255)), 1'b0);
        end
        foreach (probe_bytes[i])
            drive_beat(MODE_PIXEL, $urandom, probe_bytes[i], 1'b0);
        // position wraps back onto entry 0
        drive_beat(MODE_PALETTE, 32'h8000_0001, 8'h00, 1'b0);
        drive_beat(MODE_PIXEL, 32'hFFFF_FFFF, 8'h10, 1'b0);
        // format change keeps the load position
        set_format(FMT_8BIT);
        drive_beat(MODE_PALETTE, 32'h0123_4567, 8'hFF, 1'b0);
        drive_beat(MODE_PIXEL, 32'h0000_0000, 8'h01, 1'b0);

        for (int p = 0; p < 3; p++)
        begin
            tx_idle_pct = (p == 0) ? 33 : (p == 1) ? 62 : 0;
            rx_idle_pct = (p == 0) ? 62 : (p == 1) ? 33 : 0;
            for (int s = 0; s < 2; s++)
            begin
                set_format(pix_fmt_t'(s[0] ^ p[0]));
                if (!full_load_done && stim_fmt == FMT_8BIT)
                begin
                    for (int i = 0; i < PALETTE_ENTRIES_DEF; i++)
                        drive_beat(MODE_PALETTE, $urandom, 8'($urandom_range(255)), 1'b0);
                    full_load_done = 1'b1;
                end
                for (int n = 0; n < CHUNK_ITEMS; n++)
                    random_item(n == 50 || $urandom_range(59) == 0);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d palette loads, %0d 8-bit and %0d 4-bit pixel bytes",
                 loads_sent, bytes_8bit, bytes_4bit);
        $display("%0d color beats compared across both formats and three stall mixes",
                 colors_checked);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
